/* hdl/rmv_pkg.sv */
// Package for the running mean and variance block.
// Holds the transfer payload types, command codes and controller interface structs.
// No dependencies.
`timescale 1ns / 1ps
package rmv_pkg;

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_LOAD  = 2'd2;

   localparam int DIVIDEND_BITS = 49;
   localparam int DIV_CNT_BITS  = 6;
   localparam int ROOT_BITS     = 32;
   localparam int ROOT_CNT_BITS = 5;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] sample;
      logic [15:0]        load_count;
      logic signed [31:0] load_mean;
      logic [47:0]        load_var;
   } rmv_req_type;

   typedef struct packed {
      logic [15:0]        count_out;
      logic signed [31:0] mean_out;
      logic [47:0]        variance_out;
      logic [31:0]        std_dev_out;
   } rmv_rsp_type;

   typedef enum logic [1:0] {
      DIV_MEAN = 2'd0,
      DIV_VAR  = 2'd1,
      DIV_ERR  = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic        take_item;
      logic        preset_wr;
      logic        start_div;
      div_sel_type div_sel;
      logic        mean_wr;
      logic        t1_wr;
      logic        var_wr;
      logic        count_inc;
      logic        start_sqrt;
      logic        out_wr;
   } rmv_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       n_zero;
      logic       div_done;
      logic       sqrt_done;
   } rmv_status_type;

endpackage

/* hdl/rmv_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rmv_pkg for the dividend width.
`timescale 1ns / 1ps
module rmv_divider #(
   parameter int DIVISOR_BITS = 17
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [rmv_pkg::DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]           divisor,
   output logic [rmv_pkg::DIVIDEND_BITS-1:0] quotient,
   output logic                              done
);
   import rmv_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [DIVIDEND_BITS-1:0] quot_ff, quot_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  den_ff, den_in;
   logic [DIVISOR_BITS:0]    shifted;
   logic [DIVISOR_BITS:0]    diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      shifted = {rem_ff, quot_ff[DIVIDEND_BITS-1]};
      diff    = shifted - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in  = diff[DIVISOR_BITS-1:0];
            quot_in = {quot_ff[DIVIDEND_BITS-2:0], 1'b1};
         end else begin
            rem_in  = shifted[DIVISOR_BITS-1:0];
            quot_in = {quot_ff[DIVIDEND_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(DIVIDEND_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

endmodule

/* hdl/rmv_sqrt.sv */
// Digit-by-digit integer square root of a 64-bit radicand, one root bit per cycle.
// Depends on rmv_pkg for the root width.
`timescale 1ns / 1ps
module rmv_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [2*rmv_pkg::ROOT_BITS-1:0] radicand,
   output logic [rmv_pkg::ROOT_BITS-1:0] root,
   output logic                          done
);
   import rmv_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [ROOT_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [2*ROOT_BITS-1:0]   rad_ff, rad_in;
   logic [ROOT_BITS+1:0]     rem_ff, rem_in;
   logic [ROOT_BITS-1:0]     root_ff, root_in;
   logic [ROOT_BITS+3:0]     shifted;
   logic [ROOT_BITS+3:0]     trial;
   logic [ROOT_BITS+3:0]     diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      shifted = {rem_ff, rad_ff[2*ROOT_BITS-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = shifted - trial;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[2*ROOT_BITS-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = diff[ROOT_BITS+1:0];
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = shifted[ROOT_BITS+1:0];
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ROOT_CNT_BITS'(ROOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

/* hdl/rmv_datapath.sv */
// Datapath: statistics registers, operand selection, squarer and output register.
// Depends on rmv_pkg, rmv_divider and rmv_sqrt.
`timescale 1ns / 1ps
module rmv_datapath #(
   parameter int COUNT_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rmv_pkg::rmv_req_type    req_data,
   input  rmv_pkg::rmv_cmd_type    cmd,
   output rmv_pkg::rmv_status_type status,
   output rmv_pkg::rmv_rsp_type    rsp_data
);
   import rmv_pkg::*;

   localparam int DW = COUNT_BITS + 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   rmv_req_type             item_ff, item_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [31:0]             mean_ff, mean_in;
   logic [47:0]             var_ff, var_in;
   logic [47:0]             t1_ff, t1_in;
   logic [31:0]             ue_ff, ue_in;
   rmv_rsp_type             out_ff, out_in;

   logic [31:0]             xq;
   logic [32:0]             d;
   logic [32:0]             d_abs;
   logic [33:0]             delta;
   logic [31:0]             new_mean;
   logic [32:0]             e;
   logic [32:0]             e_abs;
   logic [63:0]             prod;
   logic [48:0]             var_sum;
   logic [31:0]             load_cnt_wide;
   logic [DIVIDEND_BITS-1:0] div_dividend;
   logic [DW-1:0]           div_divisor;
   logic [DIVIDEND_BITS-1:0] quot;
   logic                    div_done;
   logic [ROOT_BITS-1:0]    root;
   logic                    sqrt_done;

   always_comb begin
      xq       = {item_ff.sample, 16'h0000};
      d        = {xq[31], xq} - {mean_ff[31], mean_ff};
      d_abs    = d[32] ? (33'd0 - d) : d;
      delta    = d[32] ? (34'd0 - {1'b0, quot[32:0]}) : {1'b0, quot[32:0]};
      new_mean = mean_ff + delta[31:0];
      e        = {xq[31], xq} - {mean_ff[31], mean_ff};
      e_abs    = e[32] ? (33'd0 - e) : e;
      prod     = ue_ff * ue_ff;
      var_sum  = {1'b0, t1_ff} + {1'b0, quot[47:0]};
      load_cnt_wide = 32'(item_ff.load_count);
   end

   always_comb begin
      unique case (cmd.div_sel)
         DIV_MEAN: begin
            div_dividend = DIVIDEND_BITS'(d_abs);
            div_divisor  = DW'(count_ff) + 1'b1;
         end
         DIV_VAR: begin
            div_dividend = DIVIDEND_BITS'(var_ff) + DIVIDEND_BITS'(count_ff);
            div_divisor  = DW'(count_ff) + 1'b1;
         end
         DIV_ERR: begin
            div_dividend = DIVIDEND_BITS'(prod[63:16]);
            div_divisor  = DW'(count_ff);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '1;
         end
      endcase
   end

   always_comb begin
      item_in  = item_ff;
      count_in = count_ff;
      mean_in  = mean_ff;
      var_in   = var_ff;
      t1_in    = t1_ff;
      ue_in    = ue_ff;
      out_in   = out_ff;
      if (cmd.take_item) begin
         item_in = req_data;
      end
      if (cmd.preset_wr) begin
         unique case (item_ff.command)
            CMD_CLEAR: begin
               count_in = '0;
               mean_in  = '0;
               var_in   = '0;
            end
            CMD_LOAD: begin
               count_in = (load_cnt_wide > 32'(COUNT_MAX)) ? COUNT_MAX
                                                          : COUNT_BITS'(load_cnt_wide);
               mean_in  = item_ff.load_mean;
               var_in   = item_ff.load_var;
            end
            default: begin
            end
         endcase
      end
      if (cmd.mean_wr) begin
         mean_in = new_mean;
      end
      if (cmd.t1_wr) begin
         t1_in = var_ff - quot[47:0];
         ue_in = e_abs[31:0];
      end
      if (cmd.var_wr) begin
         var_in = var_sum[48] ? 48'hFFFF_FFFF_FFFF : var_sum[47:0];
      end
      if (cmd.count_inc && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.out_wr) begin
         out_in.count_out    = 16'(count_ff);
         out_in.mean_out     = mean_ff;
         out_in.variance_out = var_ff;
         out_in.std_dev_out  = root;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mean_ff  <= '0;
         var_ff   <= '0;
      end else begin
         count_ff <= count_in;
         mean_ff  <= mean_in;
         var_ff   <= var_in;
      end
      item_ff <= item_in;
      t1_ff   <= t1_in;
      ue_ff   <= ue_in;
      out_ff  <= out_in;
   end

   rmv_divider #(
      .DIVISOR_BITS(DW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (quot),
      .done     (div_done)
   );

   rmv_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_sqrt),
      .radicand ({var_ff, 16'h0000}),
      .root     (root),
      .done     (sqrt_done)
   );

   always_comb begin
      status.op        = item_ff.command;
      status.n_zero    = (count_ff == '0);
      status.div_done  = div_done;
      status.sqrt_done = sqrt_done;
   end

   assign rsp_data = out_ff;

endmodule

/* hdl/rmv_ctrl.sv */
// Controller state machine: sequences the divisions, squaring, root and output transfer.
// Depends on rmv_pkg.
`timescale 1ns / 1ps
module rmv_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  rmv_pkg::rmv_status_type status,
   output rmv_pkg::rmv_cmd_type    cmd
);
   import rmv_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_DISPATCH = 9'b000000010,
      ST_MEAN     = 9'b000000100,
      ST_VAR      = 9'b000001000,
      ST_MULT     = 9'b000010000,
      ST_ERR      = 9'b000100000,
      ST_ROOT_GO  = 9'b001000000,
      ST_SQRT     = 9'b010000000,
      ST_OUT      = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = DIV_MEAN;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.op == CMD_ADD) begin
               cmd.start_div = 1'b1;
               state_in = ST_MEAN;
            end else begin
               cmd.preset_wr = 1'b1;
               state_in = ST_ROOT_GO;
            end
         end
         ST_MEAN: begin
            if (status.div_done) begin
               cmd.mean_wr = 1'b1;
               if (status.n_zero) begin
                  cmd.count_inc = 1'b1;
                  state_in = ST_ROOT_GO;
               end else begin
                  cmd.start_div = 1'b1;
                  cmd.div_sel   = DIV_VAR;
                  state_in = ST_VAR;
               end
            end
         end
         ST_VAR: begin
            cmd.div_sel = DIV_VAR;
            if (status.div_done) begin
               cmd.t1_wr = 1'b1;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.start_div = 1'b1;
            cmd.div_sel   = DIV_ERR;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            cmd.div_sel = DIV_ERR;
            if (status.div_done) begin
               cmd.var_wr    = 1'b1;
               cmd.count_inc = 1'b1;
               state_in = ST_ROOT_GO;
            end
         end
         ST_ROOT_GO: begin
            cmd.start_sqrt = 1'b1;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (status.sqrt_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_wr = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_wr) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/running_mean_variance.sv */
// Running sample count, mean and population variance with standard deviation.
// An add runs one division for the new mean and, at a nonzero count, two more for the
// variance, then the square root; any other command runs only the square root. Each item
// may also wait at the output transfer. The shared one-bit-per-cycle divider takes 49 steps
// per division, and the one-bit-per-cycle square root takes 32 steps.
// One item is in work at a time; a finished result waits in the output register while the
// next item is taken. Depends on rmv_pkg, rmv_ctrl and rmv_datapath.
`timescale 1ns / 1ps
module running_mean_variance #(
   parameter int COUNT_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rmv_pkg::rmv_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rmv_pkg::rmv_rsp_type rsp_data
);
   import rmv_pkg::*;

   rmv_cmd_type    cmd;
   rmv_status_type status;

   rmv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rmv_datapath #(
      .COUNT_BITS(COUNT_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

/* sim/tb_running_mean_variance.sv */
// Self-checking testbench for running_mean_variance: a directed table, then random
// adds, loads, clears and unused commands, checked against a fixed-point Welford predictor.
// Depends on rmv_pkg and the running_mean_variance RTL.
`timescale 1ns / 1ps
module tb_running_mean_variance;
   import rmv_pkg::*;

   localparam int  NUM_RANDOM  = 1880;
   localparam int  QUIET_TAIL  = 200;
   localparam int  CYCLE_LIMIT = 2000000;
   localparam int  DRAIN_WAIT  = 400;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [63:0] VAR_SAT   = 64'hFFFF_FFFF_FFFF;
   localparam logic [63:0] COUNT_SAT = 64'hFFFF;

   typedef struct {
      rmv_req_type req;
      bit          typed;
      rmv_rsp_type rsp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   rmv_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rmv_rsp_type rsp_data;

   logic [15:0]        stat_count;
   logic signed [31:0] stat_mean;
   logic [47:0]        stat_var;

   rmv_rsp_type  stats_due[$];
   stim_row_type stim_table[$];
   int  error_count = 0;
   int  rsp_seen = 0;
   int  cycle_count = 0;
   int  hold_cycles = 0;
   bit  hold_request = 1'b0;
   bit  hold_taken = 1'b0;
   bit  quiet = 1'b0;
   int  n_add = 0, n_load = 0, n_clear = 0, n_unused = 0;

   running_mean_variance uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitval;
      root = 0;
      bitval = 64'd1 << 62;
      while (bitval > v) bitval = bitval >> 2;
      while (bitval != 0) begin
         if (v >= root + bitval) begin
            v = v - (root + bitval);
            root = (root >> 1) + bitval;
         end else begin
            root = root >> 1;
         end
         bitval = bitval >> 2;
      end
      return root;
   endfunction

   // Applies one command to the tracked statistics and returns the expected transfer.
   function automatic rmv_rsp_type update_stats(input rmv_req_type r);
      rmv_rsp_type o;
      logic [63:0] n, t1, t2, ue, s;
      longint      xq, d, m, e;
      case (r.command)
         CMD_ADD: begin
            n = {48'd0, stat_count};
            xq = longint'(r.sample) * 65536;
            m = longint'(stat_mean);
            d = xq - m;
            m = m + d / longint'(n + 1);
            stat_mean = m[31:0];
            if (n > 0) begin
               t1 = {16'd0, stat_var} - ({16'd0, stat_var} + n) / (n + 1);
               e = xq - m;
               ue = (e < 0) ? 64'(-e) : 64'(e);
               t2 = ((ue * ue) >> 16) / n;
               s = t1 + t2;
               stat_var = (s > VAR_SAT) ? VAR_SAT[47:0] : s[47:0];
            end
            if (n < COUNT_SAT) stat_count = stat_count + 1'b1;
         end
         CMD_CLEAR: begin
            stat_count = '0;
            stat_mean = '0;
            stat_var = '0;
         end
         CMD_LOAD: begin
            stat_count = r.load_count;
            stat_mean = r.load_mean;
            stat_var = r.load_var;
         end
         default: ;
      endcase
      o.count_out = stat_count;
      o.mean_out = stat_mean;
      o.variance_out = stat_var;
      o.std_dev_out = 32'(int_sqrt({stat_var, 16'd0}));
      return o;
   endfunction

   task automatic add_row(input logic [1:0] cmd, input logic signed [15:0] smp,
                          input logic [15:0] cnt, input logic signed [31:0] mn,
                          input logic [47:0] vr, input bit typed,
                          input rmv_rsp_type rsp);
      stim_row_type row;
      row.req = '{command: cmd, sample: smp, load_count: cnt, load_mean: mn, load_var: vr};
      row.typed = typed;
      row.rsp = rsp;
      stim_table.push_back(row);
   endtask

   function automatic rmv_req_type random_item();
      rmv_req_type r;
      int pick;
      r.sample = 16'($urandom);
      r.load_count = 16'($urandom);
      r.load_mean = $urandom;
      r.load_var = {16'($urandom), 32'($urandom)};
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         r.command = CMD_ADD;
         if ($urandom_range(0, 1)) r.sample = $signed(16'($urandom_range(0, 200))) - 16'sd100;
      end else if (pick < 90) begin
         r.command = CMD_LOAD;
         if ($urandom_range(0, 1)) r.load_count = 16'($urandom_range(0, 20));
         if ($urandom_range(0, 1)) r.load_var = r.load_var >> $urandom_range(0, 47);
      end else if (pick < 96) begin
         r.command = CMD_CLEAR;
      end else begin
         r.command = CMD_UNUSED;
      end
      return r;
   endfunction

   task automatic send_item(input rmv_req_type r, input bit typed, input rmv_rsp_type rsp);
      rmv_rsp_type predicted;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predicted = update_stats(r);
      stats_due.push_back(typed ? rsp : predicted);
      case (r.command)
         CMD_ADD:   n_add++;
         CMD_LOAD:  n_load++;
         CMD_CLEAR: n_clear++;
         default:   n_unused++;
      endcase
      @(negedge clock);
   endtask

   task automatic sender_gap();
      int gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Receiver stall: random bursts, plus a long hold requested by the sender.
   always @(negedge clock) begin
      int burst;
      burst = 0;
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_cycles <= 1999;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         burst = $urandom_range(1, 15);
         hold_cycles <= burst - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rmv_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (stats_due.size() == 0) begin
            $error("unexpected transfer: count %0d mean %0h", rsp_data.count_out,
                   rsp_data.mean_out);
            error_count++;
         end else begin
            want = stats_due.pop_front();
            if (rsp_data.count_out !== want.count_out) begin
               $error("count_out expected %0d actual %0d", want.count_out, rsp_data.count_out);
               error_count++;
            end
            if (rsp_data.mean_out !== want.mean_out) begin
               $error("mean_out expected %0h actual %0h", want.mean_out, rsp_data.mean_out);
               error_count++;
            end
            if (rsp_data.variance_out !== want.variance_out) begin
               $error("variance_out expected %0h actual %0h", want.variance_out,
                      rsp_data.variance_out);
               error_count++;
            end
            if (rsp_data.std_dev_out !== want.std_dev_out) begin
               $error("std_dev_out expected %0h actual %0h", want.std_dev_out,
                      rsp_data.std_dev_out);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d transfers pending.", cycle_count,
                  stats_due.size());
         $display("tb_running_mean_variance: errors");
         $finish;
      end
   end

   initial begin
      rmv_rsp_type zero_rsp;
      rmv_req_type r;
      stat_count = '0;
      stat_mean = '0;
      stat_var = '0;
      zero_rsp = '0;

      add_row(CMD_CLEAR, 0, 0, 0, 0, 1, zero_rsp);
      add_row(CMD_UNUSED, 16'sh7FFF, 16'hFFFF, 32'sh7FFF_FFFF, VAR_SAT[47:0], 1, zero_rsp);
      add_row(CMD_ADD, 16'sh7FFF, 0, 0, 0, 1, '{1, 32'sh7FFF_0000, 0, 0});
      add_row(CMD_ADD, -16'sh8000, 0, 0, 0, 0, zero_rsp);
      add_row(CMD_ADD, 0, 0, 0, 0, 0, zero_rsp);
      add_row(CMD_ADD, 16'sh7FFF, 0, 0, 0, 0, zero_rsp);
      add_row(CMD_CLEAR, 0, 0, 0, 0, 1, zero_rsp);
      add_row(CMD_ADD, -16'sh8000, 0, 0, 0, 1, '{1, 32'sh8000_0000, 0, 0});
      add_row(CMD_ADD, 16'sh7FFF, 0, 0, 0, 0, zero_rsp);
      add_row(CMD_LOAD, 0, 0, 0, 48'd1, 1, '{0, 0, 48'd1, 32'd256});
      add_row(CMD_ADD, 5, 0, 0, 0, 0, zero_rsp);
      add_row(CMD_LOAD, 0, 16'hFFFF, 0, 0, 1, '{16'hFFFF, 0, 0, 0});
      add_row(CMD_ADD, 16'sh7FFF, 0, 0, 0, 0, zero_rsp);
      add_row(CMD_ADD, -16'sh8000, 0, 0, 0, 0, zero_rsp);
      add_row(CMD_LOAD, 0, 16'd1, 32'sh7FFF_FFFF, VAR_SAT[47:0], 0, zero_rsp);
      add_row(CMD_ADD, -16'sh8000, 0, 0, 0, 0, zero_rsp);
      add_row(CMD_LOAD, 0, 16'd2, -32'sh8000_0000, 48'hFFFF_FFFF_FF00, 0, zero_rsp);
      add_row(CMD_ADD, 16'sh7FFF, 0, 0, 0, 0, zero_rsp);
      add_row(CMD_ADD, 16'sh7FFF, 0, 0, 0, 0, zero_rsp);
      add_row(CMD_UNUSED, 0, 0, 0, 0, 0, zero_rsp);
      add_row(CMD_LOAD, 0, 16'hFFFF, -32'sh8000_0000, VAR_SAT[47:0], 0, zero_rsp);
      add_row(CMD_ADD, 16'sh7FFF, 0, 0, 0, 0, zero_rsp);
      add_row(CMD_CLEAR, 0, 0, 0, 0, 1, zero_rsp);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         sender_gap();
         send_item(stim_table[i].req, stim_table[i].typed, stim_table[i].rsp);
      end

      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i == NUM_RANDOM / 3) hold_request = 1'b1;
         if (i == NUM_RANDOM / 2) begin
            req_valid <= 1'b0;
            wait (stats_due.size() == 0);
            @(negedge clock);
         end
         if (i == NUM_RANDOM - QUIET_TAIL) quiet = 1'b1;
         sender_gap();
         r = random_item();
         send_item(r, 1'b0, zero_rsp);
      end
      req_valid <= 1'b0;

      wait (stats_due.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Ran %0d adds, %0d loads, %0d clears and %0d unused commands;",
               n_add, n_load, n_clear, n_unused);
      $display("%0d result transfers checked, %0d mismatches.", rsp_seen, error_count);
      if (error_count == 0 && stats_due.size() == 0) begin
         $display("tb_running_mean_variance: clean");
      end else begin
         $display("tb_running_mean_variance: errors");
      end
      $finish;
   end

endmodule
